@@ hdl/rcsfd_pkg.sv @@
// ----------------------------------------------------------------------------
// rcsfd_pkg
// Shared constants and types for the RC serial frame decoder: frame layout,
// marker bytes, flag bit positions, state codes and control bundles.
// ----------------------------------------------------------------------------
package rcsfd_pkg;

  // Frame layout: start byte, 22 channel data bytes, flag byte, end byte.
  localparam int FRAME_BYTES    = 25;
  localparam int STORE_DEPTH    = FRAME_BYTES - 2;
  localparam int DATA_BYTES     = STORE_DEPTH - 1;
  localparam int CHAN_BITS      = 11;
  localparam int DATA_BITS      = DATA_BYTES * 8;
  localparam int MAX_CHANNELS   = 16;
  localparam int CHANNEL_COUNT_DEFAULT = 16;

  localparam int COUNT_W   = 5;
  localparam int INDEX_W   = 4;

  localparam logic [COUNT_W-1:0] FLAG_SLOT = COUNT_W'(STORE_DEPTH - 1);

  localparam logic [7:0] START_BYTE = 8'h0F;
  localparam logic [7:0] END_BYTE   = 8'h00;

  // Bit positions inside the flag byte.
  localparam int FRAME_LOST_BIT = 2;
  localparam int FAILSAFE_BIT   = 3;
  localparam int SWITCH_ONE_BIT = 4;
  localparam int SWITCH_TWO_BIT = 5;

  typedef enum logic [2:0] {
    ST_HUNT    = 3'b001,
    ST_COLLECT = 3'b010,
    ST_EMIT    = 3'b100
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic data_we;   // shift a data byte into the frame store
    logic flag_we;   // capture the flag byte
    logic ch_clear;  // rewind the channel readout
    logic ch_step;   // advance to the next channel
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_ch;
  } status_t;

endpackage

@@ hdl/rcsfd_ctrl.sv @@
// ----------------------------------------------------------------------------
// rcsfd_ctrl
// Controller: hunts for the start byte, counts frame bytes, checks the end
// byte and sequences the channel readout.
// ----------------------------------------------------------------------------
module rcsfd_ctrl import rcsfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output cmd_t       cmd,
  input  status_t    status
);

  state_t             state, state_next;
  logic [COUNT_W-1:0] count, count_next;
  logic               in_acc;
  logic               out_acc;

  assign in_ready  = (state != ST_EMIT);
  assign out_valid = (state == ST_EMIT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  always_comb begin
    state_next   = state;
    count_next   = count;
    cmd.data_we  = 1'b0;
    cmd.flag_we  = 1'b0;
    cmd.ch_clear = 1'b0;
    cmd.ch_step  = 1'b0;
    unique case (state)
      ST_HUNT: begin
        if (in_acc && (rx_byte == START_BYTE)) begin
          state_next = ST_COLLECT;
          count_next = '0;
        end
      end
      ST_COLLECT: begin
        if (in_acc) begin
          if (count < FLAG_SLOT) begin
            cmd.data_we = 1'b1;
            count_next  = count + COUNT_W'(1);
          end else if (count == FLAG_SLOT) begin
            cmd.flag_we = 1'b1;
            count_next  = count + COUNT_W'(1);
          end else begin
            // End byte: a bad one drops the frame without any result.
            count_next   = '0;
            cmd.ch_clear = 1'b1;
            state_next   = (rx_byte == END_BYTE) ? ST_EMIT : ST_HUNT;
          end
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          cmd.ch_step = 1'b1;
          if (status.last_ch) begin
            state_next = ST_HUNT;
          end
        end
      end
      default: begin
        state_next = ST_HUNT;
        count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

endmodule

@@ hdl/rcsfd_datapath.sv @@
// ----------------------------------------------------------------------------
// rcsfd_datapath
// Datapath: frame store as a byte shift line, flag register and the channel
// readout, which shifts the store down one 11-bit channel per result.
// ----------------------------------------------------------------------------
module rcsfd_datapath import rcsfd_pkg::*; #(
  parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           rx_byte,
  input  cmd_t                 cmd,
  output status_t              status,
  output logic [INDEX_W-1:0]   channel_index,
  output logic [CHAN_BITS-1:0] channel_value,
  output logic                 frame_lost,
  output logic                 failsafe,
  output logic                 switch_one,
  output logic                 switch_two,
  output logic                 last_channel
);

  localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(CHANNEL_COUNT - 1);

  logic [DATA_BITS-1:0] store;
  logic [7:0]           flags;
  logic [INDEX_W-1:0]   ch;

  // Bytes enter at the top, so after the last data byte frame byte 1 sits at
  // the bottom and the bit stream reads LSB first from bit zero.
  always_ff @(posedge clk) begin
    if (cmd.data_we) begin
      store <= {rx_byte, store[DATA_BITS-1:8]};
    end else if (cmd.ch_step) begin
      store <= {{CHAN_BITS{1'b0}}, store[DATA_BITS-1:CHAN_BITS]};
    end
    if (cmd.flag_we) begin
      flags <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= '0;
    end else if (cmd.ch_clear) begin
      ch <= '0;
    end else if (cmd.ch_step) begin
      ch <= ch + INDEX_W'(1);
    end
  end

  assign status.last_ch = (ch == LAST_INDEX);

  assign channel_index = ch;
  assign channel_value = store[CHAN_BITS-1:0];
  assign frame_lost    = flags[FRAME_LOST_BIT];
  assign failsafe      = flags[FAILSAFE_BIT];
  assign switch_one    = flags[SWITCH_ONE_BIT];
  assign switch_two    = flags[SWITCH_TWO_BIT];
  assign last_channel  = (ch == LAST_INDEX);

endmodule

@@ hdl/rc_serial_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// rc_serial_frame_decoder
// Decodes 25-byte RC serial frames into one result per channel with the
// frame flags attached.
// ----------------------------------------------------------------------------
//  Channel  Handshake            Payload
//  input    in_valid / in_ready  rx_byte
//  output   out_valid/ out_ready channel_index, channel_value, frame_lost,
//                                failsafe, switch_one, switch_two, last_channel
//
// Each received byte is taken while in_ready is high. A good end byte starts a readout
// of CHANNEL_COUNT results, one per cycle when out_ready is high, produced by
// shifting the frame store down one channel per result.
// in_ready is low during the readout; a stalled output simply holds it.
// Reset puts the decoder back to hunting for a start byte.
// ----------------------------------------------------------------------------
module rc_serial_frame_decoder import rcsfd_pkg::*; #(
  parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [INDEX_W-1:0]   channel_index,
  output logic [CHAN_BITS-1:0] channel_value,
  output logic                 frame_lost,
  output logic                 failsafe,
  output logic                 switch_one,
  output logic                 switch_two,
  output logic                 last_channel
);

  cmd_t    cmd;
  status_t status;

  rcsfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  rcsfd_datapath #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .rx_byte       (rx_byte),
    .cmd           (cmd),
    .status        (status),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .frame_lost    (frame_lost),
    .failsafe      (failsafe),
    .switch_one    (switch_one),
    .switch_two    (switch_two),
    .last_channel  (last_channel)
  );

endmodule

@@ bench/rcsfd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsfd_checker
// Watches both channels of the frame decoder. It keeps its own copy of the
// hunt/collect state and the frame bytes, queues the channel results that
// every accepted end byte should produce, and compares each result the
// decoder hands out, field by field, against the oldest queued one.
// ----------------------------------------------------------------------------
module rcsfd_checker import rcsfd_pkg::*; #(
  parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [7:0]           rx_byte,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [INDEX_W-1:0]   channel_index,
  input  logic [CHAN_BITS-1:0] channel_value,
  input  logic                 frame_lost,
  input  logic                 failsafe,
  input  logic                 switch_one,
  input  logic                 switch_two,
  input  logic                 last_channel,
  output int                   fail_count,
  output int                   pending,
  output int                   results_checked,
  output int                   frames_decoded,
  output int                   frames_dropped
);

  typedef struct packed {
    logic [INDEX_W-1:0]   index;
    logic [CHAN_BITS-1:0] value;
    logic                 lost;
    logic                 fs;
    logic                 sw1;
    logic                 sw2;
    logic                 last;
  } channel_result_t;

  channel_result_t    channel_queue[$];
  logic               synced;
  logic [COUNT_W-1:0] byte_count;
  logic [7:0]         frame_bytes [STORE_DEPTH];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want, input int ch);
    if (got !== want)
      report_mismatch($sformatf("channel %0d %s got %0h want %0h", ch, name, got, want));
  endtask

  // The 22 data bytes form one little-endian bit stream; channel n sits at
  // bits n*11 .. n*11+10 of it, which may straddle three bytes.
  task automatic queue_channels();
    logic [DATA_BITS-1:0] stream;
    logic [7:0]           flag_byte;
    channel_result_t      r;
    for (int i = 0; i < DATA_BYTES; i++) stream[i*8 +: 8] = frame_bytes[i];
    flag_byte = frame_bytes[STORE_DEPTH-1];
    for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
      r.index = INDEX_W'(ch);
      r.value = stream[ch*CHAN_BITS +: CHAN_BITS];
      r.lost  = flag_byte[FRAME_LOST_BIT];
      r.fs    = flag_byte[FAILSAFE_BIT];
      r.sw1   = flag_byte[SWITCH_ONE_BIT];
      r.sw2   = flag_byte[SWITCH_TWO_BIT];
      r.last  = (ch == CHANNEL_COUNT - 1);
      channel_queue.push_back(r);
    end
    frames_decoded++;
  endtask

  task automatic take_byte(input logic [7:0] b);
    if (!synced) begin
      if (b == START_BYTE) begin
        synced     = 1'b1;
        byte_count = '0;
      end
    end else if (byte_count < STORE_DEPTH) begin
      frame_bytes[byte_count] = b;
      byte_count++;
    end else begin
      synced     = 1'b0;
      byte_count = '0;
      if (b == END_BYTE) queue_channels();
      else frames_dropped++;
    end
  endtask

  always @(posedge clk) begin
    channel_result_t want;
    if (rst) begin
      synced          = 1'b0;
      byte_count      = '0;
      fail_count      = 0;
      results_checked = 0;
      frames_decoded  = 0;
      frames_dropped  = 0;
      channel_queue.delete();
    end else begin
      if (in_valid && in_ready) take_byte(rx_byte);
      if (out_valid && out_ready) begin
        if (channel_queue.size() == 0) begin
          report_mismatch($sformatf("result for channel %0d with none expected",
                                    channel_index));
        end else begin
          want = channel_queue.pop_front();
          check_field("index", 16'(channel_index), 16'(want.index), int'(want.index));
          check_field("value", 16'(channel_value), 16'(want.value), int'(want.index));
          check_field("frame_lost", 16'(frame_lost), 16'(want.lost), int'(want.index));
          check_field("failsafe", 16'(failsafe), 16'(want.fs), int'(want.index));
          check_field("switch_one", 16'(switch_one), 16'(want.sw1), int'(want.index));
          check_field("switch_two", 16'(switch_two), 16'(want.sw2), int'(want.index));
          check_field("last_channel", 16'(last_channel), 16'(want.last),
                      int'(want.index));
          results_checked++;
        end
      end
    end
    pending = channel_queue.size();
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the frame decoder bench. Drives received bytes with random gaps and
// random output stalls: a few hand-built frames first (extreme channel
// values, every flag, start bytes inside a frame, a bad end byte), then
// random frames mixed with line noise and broken frames. The checker beside
// the decoder does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
  import rcsfd_pkg::*;

  localparam int CHANNEL_COUNT = CHANNEL_COUNT_DEFAULT;
  localparam int RANDOM_BYTES  = 100;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           rx_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic [INDEX_W-1:0]   channel_index;
  logic [CHAN_BITS-1:0] channel_value;
  logic                 frame_lost;
  logic                 failsafe;
  logic                 switch_one;
  logic                 switch_two;
  logic                 last_channel;

  int fail_count;
  int pending;
  int results_checked;
  int frames_decoded;
  int frames_dropped;

  logic       no_idle;
  int         bytes_sent;
  int         random_bytes;
  logic [7:0] frame_buf [FRAME_BYTES];

  rc_serial_frame_decoder #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .channel_index(channel_index), .channel_value(channel_value),
    .frame_lost(frame_lost), .failsafe(failsafe),
    .switch_one(switch_one), .switch_two(switch_two),
    .last_channel(last_channel)
  );

  rcsfd_checker #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .channel_index(channel_index), .channel_value(channel_value),
    .frame_lost(frame_lost), .failsafe(failsafe),
    .switch_one(switch_one), .switch_two(switch_two),
    .last_channel(last_channel),
    .fail_count(fail_count), .pending(pending),
    .results_checked(results_checked),
    .frames_decoded(frames_decoded), .frames_dropped(frames_dropped)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Sends one request on the input channel and returns at the accepting edge.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < FRAME_BYTES; i++) send_byte(frame_buf[i]);
  endtask

  // Mode 0: random data, 1: all ones, 2: all zeros, 3: random with start
  // bytes sprinkled in, 4: alternating 0x55 / 0xAA.
  task automatic build_frame(input int mode, input logic [7:0] flag_byte,
                             input logic [7:0] end_byte);
    frame_buf[0] = START_BYTE;
    for (int i = 1; i <= DATA_BYTES; i++) begin
      case (mode)
        0: frame_buf[i] = 8'($urandom);
        1: frame_buf[i] = 8'hFF;
        2: frame_buf[i] = 8'h00;
        3: frame_buf[i] = ($urandom_range(0, 2) == 0) ? START_BYTE : 8'($urandom);
        default: frame_buf[i] = i[0] ? 8'h55 : 8'hAA;
      endcase
    end
    frame_buf[FRAME_BYTES-2] = flag_byte;
    frame_buf[FRAME_BYTES-1] = end_byte;
  endtask

  // Output side: each result waits a random stall before ready goes high.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int         pick;
    logic [7:0] b;
    rst          = 1'b1;
    in_valid     = 1'b0;
    rx_byte      = 8'h00;
    no_idle      = 1'b0;
    bytes_sent   = 0;
    random_bytes = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Noise while hunting, then frames with extreme contents.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hF0);
    send_byte(8'h0E);
    build_frame(1, 8'hFF, END_BYTE);
    send_frame();
    build_frame(2, 8'h00, END_BYTE);
    send_frame();
    no_idle = 1'b1;
    build_frame(3, 8'h3C, END_BYTE);
    send_frame();
    // A dropped frame with start bytes in a data, the flag and the end slot: none of them may resync.
    build_frame(1, 8'h0F, START_BYTE);
    frame_buf[5] = START_BYTE;
    send_frame();
    no_idle = 1'b0;
    send_byte(8'h01);
    build_frame(4, 8'h14, END_BYTE);
    send_frame();
    build_frame(4, 8'h28, END_BYTE);
    send_frame();

    while (random_bytes < RANDOM_BYTES) begin
      pick    = $urandom_range(0, 99);
      no_idle = ($urandom_range(0, 3) == 0);
      if (pick < 12) begin
        repeat ($urandom_range(1, 4)) begin
          b = 8'($urandom);
          if (b == START_BYTE && $urandom_range(0, 1)) b = ~b;
          send_byte(b);
          random_bytes++;
        end
      end else begin
        build_frame($urandom_range(0, 4), 8'($urandom),
                    (pick < 24) ? 8'($urandom_range(1, 255)) : END_BYTE);
        send_frame();
        random_bytes += FRAME_BYTES;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (64) @(posedge clk);

    $display("Sent %0d bytes: %0d frames decoded, %0d frames dropped.",
             bytes_sent, frames_decoded, frames_dropped);
    $display("Checked %0d channel results with random gaps and stalls.",
             results_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
